@@ design/btlp_pkg.sv @@
`default_nettype none

package btlp_pkg;

  localparam int TIMER_WIDTH = 16;

  localparam int DEBOUNCE_W = 8;
  localparam int PERIOD_W   = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int LED_W      = 3;
  localparam int PHASE_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_COUNT   = 2'd0,
    CFG_LONG_PRESS_TICKS = 2'd1,
    CFG_BLINK_PERIOD     = 2'd2
  } cfg_idx_t;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 8'd30;
  localparam logic [PERIOD_W-1:0]   LONG_PRESS_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0]   BLINK_RST      = 16'd500;

  localparam logic [DEBOUNCE_W-1:0] STABLE_MAX = 8'd255;
  localparam logic [LED_W-1:0]      LED_ALL    = 3'd7;
  localparam logic [PHASE_W-1:0]    PHASE_OFF0 = 3'd3;
  localparam logic [PHASE_W:0]      PHASE_WRAP = 4'd6;

endpackage

`default_nettype wire

@@ design/button_toggle_long_press_led_chaser_unit.sv @@
// A result is registered and shown in the cycle after its request is accepted.
// Throughput: one request per cycle; while a result waits in the output
// register, a new request is taken only in the cycle that result leaves.
// Reset (synchronous, active low) clears all debounce, timer and LED state
// and loads the configuration registers with their default values.
`default_nettype none

module button_toggle_long_press_led_chaser_unit
  import btlp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_button_raw,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [LED_W-1:0]           out_led_pattern,
  output logic                       out_run_active,
  output logic                       out_long_active,
  output logic                       out_button_clean
);

  logic [DEBOUNCE_W-1:0]  debounce_count_r;
  logic [PERIOD_W-1:0]    long_press_ticks_r;
  logic [PERIOD_W-1:0]    blink_period_r;

  logic                   last_sample_r, last_sample_nxt;
  logic [DEBOUNCE_W-1:0]  stable_ticks_r, stable_ticks_nxt;
  logic                   clean_level_r, clean_level_nxt;
  logic                   run_flag_r, run_flag_nxt;
  logic                   long_flag_r, long_flag_nxt;
  logic                   hold_on_r, hold_on_nxt;
  logic [TIMER_WIDTH-1:0] hold_ticks_r, hold_ticks_nxt;
  logic [PERIOD_W-1:0]    blink_cd_r, blink_cd_nxt;
  logic [PHASE_W-1:0]     chase_phase_r, chase_phase_nxt;
  logic [LED_W-1:0]       led_bits_r, led_bits_nxt;

  logic                   out_valid_r;
  logic [LED_W-1:0]       out_led_r;
  logic                   out_run_r, out_long_r, out_clean_r;

  logic [TIMER_WIDTH-1:0] hold_inc;
  logic [TIMER_WIDTH-1:0] hold_limit;
  logic [PHASE_W:0]       phase_inc;
  logic                   in_fire;

  assign in_ready   = !out_valid_r || out_ready;
  assign in_fire    = in_valid && in_ready;
  assign hold_inc   = hold_ticks_r + 1'b1;
  assign hold_limit = TIMER_WIDTH'(long_press_ticks_r);
  assign phase_inc  = {1'b0, chase_phase_r} + 1'b1;

  always_comb begin
    last_sample_nxt  = last_sample_r;
    stable_ticks_nxt = stable_ticks_r;
    clean_level_nxt  = clean_level_r;
    run_flag_nxt     = run_flag_r;
    long_flag_nxt    = long_flag_r;
    hold_on_nxt      = hold_on_r;
    hold_ticks_nxt   = hold_ticks_r;
    blink_cd_nxt     = blink_cd_r;
    chase_phase_nxt  = chase_phase_r;
    led_bits_nxt     = led_bits_r;

    if (hold_on_r) begin
      hold_ticks_nxt = hold_inc;
      if (hold_inc >= hold_limit) begin
        hold_on_nxt    = 1'b0;
        hold_ticks_nxt = '0;
        long_flag_nxt  = in_button_raw;
      end
    end

    if (in_button_raw != last_sample_r) begin
      last_sample_nxt  = in_button_raw;
      stable_ticks_nxt = '0;
    end else if (stable_ticks_r < STABLE_MAX) begin
      stable_ticks_nxt = stable_ticks_r + 1'b1;
    end

    if (stable_ticks_nxt >= debounce_count_r && last_sample_nxt != clean_level_r) begin
      clean_level_nxt = last_sample_nxt;
      hold_ticks_nxt  = '0;
      if (last_sample_nxt) begin
        run_flag_nxt = !run_flag_r;
        hold_on_nxt  = 1'b1;
      end else begin
        if (long_flag_nxt) begin
          run_flag_nxt  = 1'b0;
          long_flag_nxt = 1'b0;
        end
        hold_on_nxt = 1'b0;
      end
    end

    if (blink_cd_r != '0) begin
      blink_cd_nxt = blink_cd_r - 1'b1;
    end
    if (long_flag_nxt) begin
      led_bits_nxt    = LED_ALL;
      chase_phase_nxt = PHASE_OFF0;
    end else if (run_flag_nxt && blink_cd_nxt == '0) begin
      case (chase_phase_r)
        3'd0, 3'd1, 3'd2: led_bits_nxt = led_bits_r | (LED_W'(1) << chase_phase_r[1:0]);
        3'd3, 3'd4, 3'd5:
          led_bits_nxt = led_bits_r & ~(LED_W'(1) << 2'(chase_phase_r - PHASE_OFF0));
        default: led_bits_nxt = led_bits_r;
      endcase
      chase_phase_nxt = (phase_inc >= PHASE_WRAP) ? '0 : phase_inc[PHASE_W-1:0];
      blink_cd_nxt    = blink_period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_count_r   <= DEBOUNCE_RST;
      long_press_ticks_r <= LONG_PRESS_RST;
      blink_period_r     <= BLINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_COUNT:   debounce_count_r   <= cfg_wdata[DEBOUNCE_W-1:0];
        CFG_LONG_PRESS_TICKS: long_press_ticks_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_BLINK_PERIOD:     blink_period_r     <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r  <= 1'b0;
      stable_ticks_r <= '0;
      clean_level_r  <= 1'b0;
      run_flag_r     <= 1'b0;
      long_flag_r    <= 1'b0;
      hold_on_r      <= 1'b0;
      hold_ticks_r   <= '0;
      blink_cd_r     <= '0;
      chase_phase_r  <= '0;
      led_bits_r     <= '0;
    end else if (in_fire) begin
      last_sample_r  <= last_sample_nxt;
      stable_ticks_r <= stable_ticks_nxt;
      clean_level_r  <= clean_level_nxt;
      run_flag_r     <= run_flag_nxt;
      long_flag_r    <= long_flag_nxt;
      hold_on_r      <= hold_on_nxt;
      hold_ticks_r   <= hold_ticks_nxt;
      blink_cd_r     <= blink_cd_nxt;
      chase_phase_r  <= chase_phase_nxt;
      led_bits_r     <= led_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_led_r   <= led_bits_nxt;
      out_run_r   <= run_flag_nxt;
      out_long_r  <= long_flag_nxt;
      out_clean_r <= clean_level_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_pattern  = out_led_r;
  assign out_run_active   = out_run_r;
  assign out_long_active  = out_long_r;
  assign out_button_clean = out_clean_r;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
  import btlp_pkg::*;

  typedef struct packed {
    logic [LED_W-1:0] led;
    logic             run;
    logic             long_mode;
    logic             clean;
  } led_status_t;

  localparam int QUIET_LIMIT = 2000;
  localparam int GAP_MAX     = 17;
  localparam int SINK_HOLD   = 150;
  localparam int NUM_SETS    = 7;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_DEBOUNCE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_button_raw = 1'b0;
  logic                  out_ready     = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic [LED_W-1:0]      out_led_pattern;
  logic                  out_run_active;
  logic                  out_long_active;
  logic                  out_button_clean;

  button_toggle_long_press_led_chaser_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_button_raw    (in_button_raw),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_pattern  (out_led_pattern),
    .out_run_active   (out_run_active),
    .out_long_active  (out_long_active),
    .out_button_clean (out_button_clean)
  );

  always #5 clk = ~clk;

  // Mirror of the block's registers and state.
  logic [DEBOUNCE_W-1:0]  debounce_cfg;
  logic [PERIOD_W-1:0]    long_press_cfg;
  logic [PERIOD_W-1:0]    blink_cfg;
  logic                   btn_last;
  logic                   btn_clean;
  logic                   run_on;
  logic                   long_on;
  logic                   hold_on;
  logic [DEBOUNCE_W-1:0]  stable_cnt;
  logic [TIMER_WIDTH-1:0] hold_cnt;
  logic [PERIOD_W-1:0]    blink_cnt;
  logic [PHASE_W-1:0]     chase_idx;
  logic [LED_W-1:0]       led_state;

  led_status_t led_expected[$];
  bit          button_samples[$];
  led_status_t led_seen;
  led_status_t led_want;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   src_gap   = 0;
  int   sink_wait = 0;
  bit   src_calm  = 1'b0;
  bit   sink_calm = 1'b0;
  bit   raw_level = 1'b0;

  int samples_done  = 0;
  int results_done  = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int items_queued  = 0;
  int presses_seen  = 0;
  int long_entries  = 0;
  int settings_used = 1;

  int set_debounce[NUM_SETS] = '{1, 3, 8, 2, 255, 1, 4};
  int set_long[NUM_SETS]     = '{1, 20, 40, 12, 65535, 28, 9};
  int set_blink[NUM_SETS]    = '{1, 4, 2, 28, 65535, 65535, 1};
  int set_items[NUM_SETS]    = '{150, 150, 150, 150, 560, 150, 150};

  function automatic led_status_t sample_button(input logic raw);
    led_status_t res;
    if (hold_on) begin
      hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt >= long_press_cfg) begin
        hold_on  = 1'b0;
        hold_cnt = '0;
        if (raw && !long_on) long_entries++;
        long_on = raw;
      end
    end
    if (raw != btn_last) begin
      btn_last   = raw;
      stable_cnt = '0;
    end else if (stable_cnt != STABLE_MAX) begin
      stable_cnt = stable_cnt + 1'b1;
    end
    if (stable_cnt >= debounce_cfg && btn_last != btn_clean) begin
      btn_clean = btn_last;
      hold_on   = btn_clean;
      hold_cnt  = '0;
      if (btn_clean) begin
        run_on = !run_on;
        presses_seen++;
      end else if (long_on) begin
        run_on  = 1'b0;
        long_on = 1'b0;
      end
    end
    if (blink_cnt != '0) blink_cnt = blink_cnt - 1'b1;
    if (long_on) begin
      led_state = LED_ALL;
      chase_idx = PHASE_OFF0;
    end else if (run_on && blink_cnt == '0) begin
      if (chase_idx < PHASE_OFF0) led_state[chase_idx] = 1'b1;
      else led_state[chase_idx - PHASE_OFF0] = 1'b0;
      chase_idx = ({1'b0, chase_idx} + 1'b1 >= PHASE_WRAP) ? '0 : chase_idx + 1'b1;
      blink_cnt = blink_cfg;
    end
    res.led       = led_state;
    res.run       = run_on;
    res.long_mode = long_on;
    res.clean     = btn_clean;
    return res;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  always @(posedge clk) begin
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (!rst_n) begin
      debounce_cfg   = DEBOUNCE_RST;
      long_press_cfg = LONG_PRESS_RST;
      blink_cfg      = BLINK_RST;
      btn_last       = 1'b0;
      btn_clean      = 1'b0;
      run_on         = 1'b0;
      long_on        = 1'b0;
      hold_on        = 1'b0;
      stable_cnt     = '0;
      hold_cnt       = '0;
      blink_cnt      = '0;
      chase_idx      = '0;
      led_state      = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE_COUNT:   debounce_cfg   = cfg_wdata[DEBOUNCE_W-1:0];
          CFG_LONG_PRESS_TICKS: long_press_cfg = cfg_wdata;
          CFG_BLINK_PERIOD:     blink_cfg      = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        led_seen = {out_led_pattern, out_run_active, out_long_active, out_button_clean};
        results_done++;
        if (led_expected.size() == 0) begin
          if (mismatches < 10)
            $display("LED result %0d with no request pending: led=%0d run=%0b long=%0b clean=%0b",
                     results_done, led_seen.led, led_seen.run, led_seen.long_mode,
                     led_seen.clean);
          mismatches++;
        end else begin
          led_want = led_expected.pop_front();
          if (led_seen.led !== led_want.led || led_seen.run !== led_want.run ||
              led_seen.long_mode !== led_want.long_mode ||
              led_seen.clean !== led_want.clean) begin
            if (mismatches < 10) begin
              $display("LED result %0d: expected led=%0d run=%0b long=%0b clean=%0b",
                       results_done, led_want.led, led_want.run, led_want.long_mode,
                       led_want.clean);
              $display("  actual led=%0d run=%0b long=%0b clean=%0b",
                       led_seen.led, led_seen.run, led_seen.long_mode, led_seen.clean);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        led_expected.push_back(sample_button(in_button_raw));
        samples_done++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_button_raw <= 1'b0;
      src_gap       = 0;
    end else if (!in_valid || in_taken) begin
      if (src_gap != 0) begin
        in_valid <= 1'b0;
        src_gap--;
      end else if (button_samples.size() != 0) begin
        in_valid      <= 1'b1;
        in_button_raw <= button_samples.pop_front();
        if ($urandom_range(0, 40) == 0) src_calm = !src_calm;
        src_gap = draw_wait(src_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Twice in the run the receiver stops for a long stretch so the block backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 40) == 0) sink_calm = !sink_calm;
        sink_wait = (results_done == 350 || results_done == 1200) ? SINK_HOLD
                                                                  : draw_wait(sink_calm);
      end
      if (sink_wait != 0) begin
        out_ready <= 1'b0;
        sink_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("Timeout: nothing moved for %0d cycles", QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_level(input bit level, input int count);
    repeat (count) button_samples.push_back(level);
    items_queued += count;
    raw_level = level;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int dbc, input int hold_len, input int period);
    write_reg(CFG_DEBOUNCE_COUNT, CFG_DATA_W'(dbc));
    write_reg(CFG_LONG_PRESS_TICKS, CFG_DATA_W'(hold_len));
    write_reg(CFG_BLINK_PERIOD, CFG_DATA_W'(period));
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (samples_done != items_queued || led_expected.size() != 0 || in_valid);
    repeat (2) @(negedge clk);
  endtask

  task automatic gen_presses(input int n, input int dbc, input int hold_len, input int period);
    int first;
    int r;
    int lo;
    int span;
    first = items_queued;
    while (items_queued - first < n) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if (r < 30 || hold_len > 300) begin
          lo   = dbc + 1;
          span = (hold_len > 300) ? 300 : hold_len;
        end else begin
          lo   = dbc + hold_len + 1;
          span = 8;
        end
        push_level(1'b1, lo + $urandom_range(0, span));
        span = 3 * period + 4;
        push_level(1'b0, dbc + 1 + $urandom_range(0, (span > 40) ? 40 : span));
      end else if (r < 85) begin
        push_level(!raw_level, $urandom_range(1, (dbc > 0) ? dbc : 1));
        push_level(!raw_level, dbc + 1);
      end else begin
        repeat ($urandom_range(1, 8)) push_level(1'($urandom_range(0, 1)), 1);
      end
    end
  endtask

  localparam logic [19:0] ZERO_CFG_TAPS = 20'b0110_0110_0000_0010_1011;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Power-on settings: a press, a glitch too short to count, then a release.
    push_level(1'b1, 40);
    push_level(1'b0, 5);
    push_level(1'b1, 40);
    push_level(1'b0, 40);
    wait_idle();

    configure(0, 0, 0);
    for (int i = 0; i < 20; i++) push_level(ZERO_CFG_TAPS[i], 1);
    gen_presses(150, 0, 0, 0);

    for (int s = 0; s < NUM_SETS; s++) begin
      wait_idle();
      configure(set_debounce[s], set_long[s], set_blink[s]);
      gen_presses(set_items[s], set_debounce[s], set_long[s], set_blink[s]);
    end

    wait_idle();
    repeat (5) @(posedge clk);
    mismatches += led_expected.size();
    $display("Ran %0d button samples under %0d register settings.", samples_done, settings_used);
    $display("The block saw %0d accepted presses and %0d long holds.", presses_seen,
             long_entries);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
